FILE: sv/line_raster_page_framebuffer_core_macros.svh
// ----------------------------------------------------------------------------
// Line raster page framebuffer: assertion macros
// Shared shorthand for the concurrent checks of the core.
// ----------------------------------------------------------------------------
`ifndef LINE_RASTER_PAGE_FRAMEBUFFER_CORE_MACROS_SVH
`define LINE_RASTER_PAGE_FRAMEBUFFER_CORE_MACROS_SVH

// Same-cycle implication, checked on aclk outside of reset.
`define LRPF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on aclk outside of reset.
`define LRPF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/lrpf_pkg.sv
// ----------------------------------------------------------------------------
// lrpf_pkg
// Default geometry, widths, command and color codes and the pixel record
// shared by the line raster framebuffer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lrpf_pkg;

    // Default geometry of the panel.
    localparam int DEF_SCREEN_WIDTH = 128;
    localparam int DEF_PAGE_COUNT   = 8;

    // Field widths.
    localparam int COORD_W = 10;
    localparam int CMD_W   = 2;
    localparam int COLOR_W = 2;
    localparam int BYTE_W  = 8;
    localparam int PAGE_W  = 3;
    localparam int COUNT_W = 11;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // Color codes; any other nonzero code sets pixels.
    localparam logic [COLOR_W-1:0] COLOR_CLEAR = 2'd0;
    localparam logic [COLOR_W-1:0] COLOR_SET   = 2'd1;
    localparam logic [COLOR_W-1:0] COLOR_GRAY  = 2'd2;

    // One pixel produced by the line walker, in screen coordinates.
    typedef struct packed {
        logic                      valid;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      set_px;
    } lrpf_pix_t;

endpackage

`default_nettype wire

FILE: sv/line_raster_page_framebuffer_core.sv
// ----------------------------------------------------------------------------
// line_raster_page_framebuffer_core
// Page-organized monochrome framebuffer with line drawing, page clearing
// and byte readback, built around one read-modify-write byte memory.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one command per transaction: draw a line, read a
//   byte, or clear a range of pages. Every command returns exactly one
//   transaction on the m_ channel: read_data for a read, pixels_plotted
//   for a draw, zeros otherwise.
//   One command is worked on at a time. A draw walks N pixels, N being the
//   major-axis span plus one; pixels flow at one per cycle through the
//   memory read, modify and write-back, with the last written byte
//   forwarded to a following pixel in the same byte. A clear zeroes
//   SCREEN_WIDTH bytes per page cleared. After reset the core zeroes all
//   SCREEN_WIDTH * PAGE_COUNT bytes (1024 at the default size) one byte per
//   cycle, with s_ready low meanwhile.
//   The result sits in an output register, so a new command is accepted
//   while the receiver stalls; the core then holds once the next result is
//   ready, until the output register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module line_raster_page_framebuffer_core #(
    parameter int SCREEN_WIDTH = lrpf_pkg::DEF_SCREEN_WIDTH,
    parameter int PAGE_COUNT   = lrpf_pkg::DEF_PAGE_COUNT
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic        [lrpf_pkg::CMD_W-1:0]   s_cmd,
    input  wire logic signed [lrpf_pkg::COORD_W-1:0] s_x_start,
    input  wire logic signed [lrpf_pkg::COORD_W-1:0] s_y_start,
    input  wire logic signed [lrpf_pkg::COORD_W-1:0] s_x_end,
    input  wire logic signed [lrpf_pkg::COORD_W-1:0] s_y_end,
    input  wire logic        [lrpf_pkg::COLOR_W-1:0] s_line_color,
    input  wire logic        [lrpf_pkg::COORD_W-1:0] s_byte_addr,
    input  wire logic        [lrpf_pkg::PAGE_W-1:0]  s_page_first,
    input  wire logic        [lrpf_pkg::PAGE_W-1:0]  s_page_last,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic             [lrpf_pkg::BYTE_W-1:0]  m_read_data,
    output logic             [lrpf_pkg::COUNT_W-1:0] m_pixels_plotted
);
    import lrpf_pkg::*;
    `include "line_raster_page_framebuffer_core_macros.svh"

    localparam int FRAME_SIZE = SCREEN_WIDTH * PAGE_COUNT;
    localparam int ADDR_W     = $clog2(FRAME_SIZE);
    localparam logic [12:0] FRAME_LIM = 13'(FRAME_SIZE);
    localparam logic [8:0]  X_LIM     = 9'(SCREEN_WIDTH);
    localparam logic [8:0]  Y_LIM     = 9'(PAGE_COUNT * 8);
    localparam logic [4:0]  PAGE_MAX  = 5'(PAGE_COUNT - 1);

    typedef enum logic [2:0] {
        ST_INIT, ST_IDLE, ST_LINE, ST_READ, ST_CLEAR, ST_DONE
    } core_state_t;

    core_state_t         state_reg, state_next;
    logic [ADDR_W-1:0]   clr_addr_reg, clr_addr_next, clr_last_reg, clr_last_next;
    logic                rd_ok_reg, rd_ok_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [BYTE_W-1:0]   res_data_reg, res_data_next;
    logic [COUNT_W-1:0]  res_count_reg, res_count_next;
    logic                m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0]   m_data_reg, m_data_next;
    logic [COUNT_W-1:0]  m_count_reg, m_count_next;

    logic                p2_valid_reg, p2_set_reg;
    logic [ADDR_W-1:0]   p2_addr_reg;
    logic [BYTE_W-1:0]   p2_mask_reg;
    logic                fwd_valid_reg;
    logic [ADDR_W-1:0]   fwd_addr_reg;
    logic [BYTE_W-1:0]   fwd_data_reg;

    logic                s_accept, walk_start, walk_busy;
    lrpf_pix_t           walk_pix;
    logic                s1_hit;
    logic [ADDR_W-1:0]   s1_addr;
    logic [BYTE_W-1:0]   s1_mask, s2_cur, s2_new;
    logic                rd_in_range, clr_any;
    logic [4:0]          pf_w, pl_w, pl_eff;
    logic                ram_wr_en, ram_rd_en;
    logic [ADDR_W-1:0]   ram_wr_addr, ram_rd_addr;
    logic [BYTE_W-1:0]   ram_wr_data, ram_rd_data;
    logic                line_done, out_free;

    assign s_accept   = s_valid && s_ready;
    assign walk_start = s_accept && (s_cmd == CMD_DRAW);
    assign out_free   = !m_valid_reg || m_ready;

    // Line stepper.
    lrpf_line_walk u_walk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (walk_start),
        .x_start    (s_x_start),
        .y_start    (s_y_start),
        .x_end      (s_x_end),
        .y_end      (s_y_end),
        .line_color (s_line_color),
        .busy       (walk_busy),
        .pix        (walk_pix)
    );

    // Framebuffer memory.
    lrpf_frame_ram #(
        .DEPTH  (FRAME_SIZE),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Pixel stage one: screen clip, byte address and bit mask.
    always_comb begin
        s1_hit  = walk_pix.valid
                  && !walk_pix.x[COORD_W-1] && (walk_pix.x[8:0] < X_LIM)
                  && !walk_pix.y[COORD_W-1] && (walk_pix.y[8:0] < Y_LIM);
        s1_addr = ADDR_W'(walk_pix.y[8:3] * SCREEN_WIDTH + walk_pix.x[8:0]);
        s1_mask = BYTE_W'(1) << walk_pix.y[2:0];
    end

    // Pixel stage two: merge the bit into the byte, forwarding the last write.
    always_comb begin
        s2_cur = (fwd_valid_reg && (fwd_addr_reg == p2_addr_reg)) ? fwd_data_reg
                                                                  : ram_rd_data;
        s2_new = p2_set_reg ? (s2_cur | p2_mask_reg) : (s2_cur & ~p2_mask_reg);
    end

    // Read-command range check and clear-command page span.
    always_comb begin
        rd_in_range = {3'b000, s_byte_addr} < FRAME_LIM;
        pf_w        = {2'b00, s_page_first};
        pl_w        = {2'b00, s_page_last};
        pl_eff      = (pl_w > PAGE_MAX) ? PAGE_MAX : pl_w;
        clr_any     = (pf_w <= pl_eff) && (pf_w <= PAGE_MAX);
    end

    // Memory port selection.
    always_comb begin
        ram_rd_en   = s1_hit || (s_accept && (s_cmd == CMD_READ) && rd_in_range);
        ram_rd_addr = s1_hit ? s1_addr : ADDR_W'(s_byte_addr);
        ram_wr_en   = p2_valid_reg || (state_reg == ST_INIT) || (state_reg == ST_CLEAR);
        ram_wr_addr = p2_valid_reg ? p2_addr_reg : clr_addr_reg;
        ram_wr_data = p2_valid_reg ? s2_new : '0;
    end

    assign line_done = !walk_busy && !walk_pix.valid && !p2_valid_reg;

    // Command sequencer and output register.
    always_comb begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        clr_last_next  = clr_last_reg;
        rd_ok_next     = rd_ok_reg;
        count_next     = count_reg;
        res_data_next  = res_data_reg;
        res_count_next = res_count_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        m_count_next   = m_count_reg;
        s_ready        = (state_reg == ST_IDLE);

        case (state_reg)
            ST_INIT: begin
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == clr_last_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    res_data_next  = '0;
                    res_count_next = '0;
                    count_next     = '0;
                    rd_ok_next     = rd_in_range;
                    clr_addr_next  = ADDR_W'(pf_w * SCREEN_WIDTH);
                    clr_last_next  = ADDR_W'(pl_eff * SCREEN_WIDTH + (SCREEN_WIDTH - 1));
                    case (s_cmd)
                        CMD_DRAW:  state_next = ST_LINE;
                        CMD_READ:  state_next = ST_READ;
                        CMD_CLEAR: state_next = clr_any ? ST_CLEAR : ST_DONE;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_LINE: begin
                if (s1_hit) begin
                    count_next = count_reg + COUNT_W'(1);
                end
                if (line_done) begin
                    res_count_next = count_reg;
                    state_next     = ST_DONE;
                end
            end
            ST_READ: begin
                res_data_next = rd_ok_reg ? ram_rd_data : '0;
                state_next    = ST_DONE;
            end
            ST_CLEAR: begin
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == clr_last_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_data_reg;
                    m_count_next = res_count_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, counters and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            clr_addr_reg <= '0;
            clr_last_reg <= ADDR_W'(FRAME_SIZE - 1);
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            clr_last_reg <= clr_last_next;
            m_valid_reg  <= m_valid_next;
        end
        rd_ok_reg     <= rd_ok_next;
        count_reg     <= count_next;
        res_data_reg  <= res_data_next;
        res_count_reg <= res_count_next;
        m_data_reg    <= m_data_next;
        m_count_reg   <= m_count_next;
    end

    // Pixel pipeline and write-forwarding registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end else begin
            p2_valid_reg  <= s1_hit;
            fwd_valid_reg <= p2_valid_reg;
        end
        p2_addr_reg  <= s1_addr;
        p2_mask_reg  <= s1_mask;
        p2_set_reg   <= walk_pix.set_px;
        fwd_addr_reg <= p2_addr_reg;
        fwd_data_reg <= s2_new;
    end

    assign m_valid          = m_valid_reg;
    assign m_read_data      = m_data_reg;
    assign m_pixels_plotted = m_count_reg;

    // Checks.
    `LRPF_ASSERT_NEXT(a_one_at_a_time, s_accept, !s_ready, "command accepted while busy")
    `LRPF_ASSERT_NOW(a_pix_in_line, p2_valid_reg, state_reg == ST_LINE, "pixel write outside draw")
    `LRPF_ASSERT_NOW(a_clr_bound, state_reg == ST_CLEAR, clr_addr_reg <= clr_last_reg, "clear overran")
    `LRPF_ASSERT_NEXT(a_result_out, (state_reg == ST_DONE) && out_free, m_valid_reg, "result lost")

endmodule

`default_nettype wire

FILE: sv/lrpf_frame_ram.sv
// ----------------------------------------------------------------------------
// lrpf_frame_ram
// Framebuffer byte store: one write port and one read port with registered
// read data (read-first when both hit the same entry).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lrpf_frame_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  wire logic                        aclk,
    input  wire logic                        wr_en,
    input  wire logic [ADDR_W-1:0]           wr_addr,
    input  wire logic [lrpf_pkg::BYTE_W-1:0] wr_data,
    input  wire logic                        rd_en,
    input  wire logic [ADDR_W-1:0]           rd_addr,
    output logic      [lrpf_pkg::BYTE_W-1:0] rd_data
);
    import lrpf_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: sv/lrpf_line_walk.sv
// ----------------------------------------------------------------------------
// lrpf_line_walk
// Bresenham line stepper: after the axis-swap and end-ordering setup states,
// one pixel per cycle along the major axis, with its color already resolved.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lrpf_line_walk (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                start,
    input  wire logic signed [lrpf_pkg::COORD_W-1:0] x_start,
    input  wire logic signed [lrpf_pkg::COORD_W-1:0] y_start,
    input  wire logic signed [lrpf_pkg::COORD_W-1:0] x_end,
    input  wire logic signed [lrpf_pkg::COORD_W-1:0] y_end,
    input  wire logic        [lrpf_pkg::COLOR_W-1:0] line_color,
    output logic                                     busy,
    output lrpf_pkg::lrpf_pix_t                      pix
);
    import lrpf_pkg::*;

    typedef enum logic [1:0] {W_IDLE, W_SWAP, W_ORDER, W_RUN} walk_state_t;

    walk_state_t               state_reg, state_next;
    logic signed [COORD_W-1:0] xa_reg, xa_next, ya_reg, ya_next;
    logic signed [COORD_W-1:0] xb_reg, xb_next, yb_reg, yb_next;
    logic                      steep_reg, steep_next;
    logic [COLOR_W-1:0]        color_reg, color_next;
    logic signed [COORD_W-1:0] maj_reg, maj_next, min_reg, min_next;
    logic [COUNT_W-1:0]        dx_reg, dx_next, dy_reg, dy_next, rem_reg, rem_next;
    logic signed [COUNT_W:0]   err_reg, err_next;
    logic                      up_reg, up_next;
    lrpf_pix_t                 pix_reg, pix_next;

    logic signed [COUNT_W-1:0] dxa, dya, dmaj, dmin;
    logic [COUNT_W-1:0]        adx, ady;
    logic                      steep_c, swap_ends;
    logic signed [COORD_W-1:0] a_maj, a_min, b_maj, b_min;
    logic signed [COUNT_W:0]   err_dec;
    logic                      set_c;

    // Setup arithmetic: absolute spans, axis swap and end ordering.
    always_comb begin
        dxa     = {xb_reg[COORD_W-1], xb_reg} - {xa_reg[COORD_W-1], xa_reg};
        dya     = {yb_reg[COORD_W-1], yb_reg} - {ya_reg[COORD_W-1], ya_reg};
        adx     = dxa[COUNT_W-1] ? COUNT_W'(-dxa) : COUNT_W'(dxa);
        ady     = dya[COUNT_W-1] ? COUNT_W'(-dya) : COUNT_W'(dya);
        steep_c = ady > adx;

        swap_ends = xa_reg > xb_reg;
        a_maj = swap_ends ? xb_reg : xa_reg;
        a_min = swap_ends ? yb_reg : ya_reg;
        b_maj = swap_ends ? xa_reg : xb_reg;
        b_min = swap_ends ? ya_reg : yb_reg;
        dmaj  = {b_maj[COORD_W-1], b_maj} - {a_maj[COORD_W-1], a_maj};
        dmin  = {b_min[COORD_W-1], b_min} - {a_min[COORD_W-1], a_min};
    end

    // Color of the current pixel; gray follows the major coordinate parity.
    always_comb begin
        case (color_reg)
            COLOR_CLEAR: set_c = 1'b0;
            COLOR_GRAY:  set_c = ~maj_reg[0];
            default:     set_c = 1'b1;
        endcase
    end

    // Sequencer: latch, swap axes, order ends, then step.
    always_comb begin
        state_next = state_reg;
        xa_next    = xa_reg;
        ya_next    = ya_reg;
        xb_next    = xb_reg;
        yb_next    = yb_reg;
        steep_next = steep_reg;
        color_next = color_reg;
        maj_next   = maj_reg;
        min_next   = min_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        rem_next   = rem_reg;
        err_next   = err_reg;
        up_next    = up_reg;
        pix_next   = '0;
        err_dec    = err_reg - $signed({1'b0, dy_reg});

        case (state_reg)
            W_IDLE: begin
                if (start) begin
                    xa_next    = x_start;
                    ya_next    = y_start;
                    xb_next    = x_end;
                    yb_next    = y_end;
                    color_next = line_color;
                    state_next = W_SWAP;
                end
            end
            W_SWAP: begin
                steep_next = steep_c;
                if (steep_c) begin
                    xa_next = ya_reg;
                    ya_next = xa_reg;
                    xb_next = yb_reg;
                    yb_next = xb_reg;
                end
                state_next = W_ORDER;
            end
            W_ORDER: begin
                maj_next   = a_maj;
                min_next   = a_min;
                dx_next    = COUNT_W'(dmaj);
                dy_next    = dmin[COUNT_W-1] ? COUNT_W'(-dmin) : COUNT_W'(dmin);
                rem_next   = COUNT_W'(dmaj);
                err_next   = $signed({2'b00, dmaj[COUNT_W-1:1]});
                up_next    = a_min < b_min;
                state_next = W_RUN;
            end
            W_RUN: begin
                pix_next.valid  = 1'b1;
                pix_next.x      = steep_reg ? min_reg : maj_reg;
                pix_next.y      = steep_reg ? maj_reg : min_reg;
                pix_next.set_px = set_c;
                maj_next        = maj_reg + COORD_W'(1);
                rem_next        = rem_reg - COUNT_W'(1);
                if (err_dec < 0) begin
                    min_next = up_reg ? min_reg + COORD_W'(1) : min_reg - COORD_W'(1);
                    err_next = err_dec + $signed({1'b0, dx_reg});
                end else begin
                    err_next = err_dec;
                end
                if (rem_reg == '0) begin
                    state_next = W_IDLE;
                end
            end
            default: begin
                state_next = W_IDLE;
            end
        endcase
    end

    // State and registered pixel output.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= W_IDLE;
            pix_reg   <= '0;
        end else begin
            state_reg <= state_next;
            pix_reg   <= pix_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        xa_reg    <= xa_next;
        ya_reg    <= ya_next;
        xb_reg    <= xb_next;
        yb_reg    <= yb_next;
        steep_reg <= steep_next;
        color_reg <= color_next;
        maj_reg   <= maj_next;
        min_reg   <= min_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        rem_reg   <= rem_next;
        err_reg   <= err_next;
        up_reg    <= up_next;
    end

    assign busy = (state_reg != W_IDLE);
    assign pix  = pix_reg;

endmodule

`default_nettype wire
